[hdl/gcm_pkg.sv]
// Shared types and constants for the greedy change maker.
// Holds the denomination table, field widths and the controller-to-datapath command.
// No dependencies.
package gcm_pkg;

	localparam int DENOM_W   = 16;
	localparam int COUNT_W   = 17;
	localparam int IDX_W     = 4;
	localparam int NUM_BILLS = 7;
	localparam int NUM_DENOM = 15;

	// Largest denomination of each mode, divided out by reciprocal multiplication
	localparam int DENOM_TOP_BILL = 50000;
	localparam int DENOM_TOP_COIN = 200;

	localparam logic [IDX_W-1:0]   IDX_FIRST_BILL = IDX_W'(0);
	localparam logic [IDX_W-1:0]   IDX_FIRST_COIN = IDX_W'(NUM_BILLS);
	localparam logic [IDX_W-1:0]   IDX_LAST       = IDX_W'(NUM_DENOM - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

	// Configuration register word indexes
	localparam logic REG_INCLUDE_BILLS = 1'b0;

	typedef struct packed {
		logic             load;      // take a new amount
		logic             mul_lo;    // partial product of the low amount half
		logic             mul_hi;    // add the partial product of the high half
		logic             rem_calc;  // estimated quotient and remainder
		logic             rem_fix;   // correct the estimate by one
		logic             emit;      // produce the result for idx into the output register
		logic             use_quot;  // first entry: count comes from the quotient
		logic [IDX_W-1:0] idx;       // table entry being worked on
	} gcm_cmd_t;

	// Notes of 500 down to 5 euro, then coins of 2 euro down to 1 cent
	function automatic logic [DENOM_W-1:0] denom_of(input logic [IDX_W-1:0] idx);
		logic [DENOM_W-1:0] d;
		case (idx)
			4'd0:    d = 16'd50000;
			4'd1:    d = 16'd20000;
			4'd2:    d = 16'd10000;
			4'd3:    d = 16'd5000;
			4'd4:    d = 16'd2000;
			4'd5:    d = 16'd1000;
			4'd6:    d = 16'd500;
			4'd7:    d = 16'd200;
			4'd8:    d = 16'd100;
			4'd9:    d = 16'd50;
			4'd10:   d = 16'd20;
			4'd11:   d = 16'd10;
			4'd12:   d = 16'd5;
			4'd13:   d = 16'd2;
			default: d = 16'd1;
		endcase
		return d;
	endfunction

endpackage

[hdl/greedy_change_maker.sv]
// Top level of the greedy change maker: configuration register, sequencer
// and datapath. Depends on gcm_pkg, gcm_ctrl and gcm_dp.
//
// Usage
//   Input channel (in_valid/in_ready, amount_cents): one item is an amount in
//   cents. It is split greedily over the euro table, 2 euro down to 1 cent,
//   or 500 euro down to 1 cent when include_bills is set.
//   Output channel (out_valid/out_ready): one item per table entry, 8 or 15
//   per amount, with denomination_cents, piece_count and is_last, which marks
//   the 1-cent result closing the amount.
//   Sequence: after acceptance the first denomination divides the amount by
//   reciprocal multiplication in steps: two partial products, the remainder,
//   one correction. Each further entry then takes one compare-subtract step.
//   All entries of an amount are walked before the next amount is taken.
//   Stalls: the table walk holds while the output register is full and not
//   taken. A new amount is taken as soon as the last result sits in the output
//   register, even if the receiver has not yet taken it.
//   Reset: arst_n clears the sequencer, the output valid and include_bills.
//   APB: one register, include_bills at byte address 0; pready is always high.
module greedy_change_maker
	import gcm_pkg::*;
#(
	parameter int AMOUNT_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// input items
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [AMOUNT_BITS-1:0] amount_cents,
	// result items
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [DENOM_W-1:0]     denomination_cents,
	output logic [COUNT_W-1:0]     piece_count,
	output logic                   is_last
);

	logic     include_bills_q;
	logic     reg_hit;
	gcm_cmd_t cmd;

	assign pready  = 1'b1;
	// Word index is address bit 2; anything past the single register is ignored
	assign reg_hit = (paddr[2] == REG_INCLUDE_BILLS);
	assign prdata  = reg_hit ? {31'd0, include_bills_q} : 32'd0;

	// Take the low bit of a write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			include_bills_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_hit) begin
			include_bills_q <= pwdata[0];
		end
	end

	gcm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.include_bills (include_bills_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cmd           (cmd)
	);

	gcm_dp #(
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_dp (
		.clk                (clk),
		.cmd                (cmd),
		.amount_cents       (amount_cents),
		.denomination_cents (denomination_cents),
		.piece_count        (piece_count),
		.is_last            (is_last)
	);

endmodule

[hdl/gcm_ctrl.sv]
// Sequencer for the greedy change maker: input handshake, division phases,
// table walk and output valid. Depends on gcm_pkg.
module gcm_ctrl
	import gcm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     include_bills,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output gcm_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL_LO = 3'd1;
	localparam logic [2:0] ST_MUL_HI = 3'd2;
	localparam logic [2:0] ST_REM    = 3'd3;
	localparam logic [2:0] ST_FIX    = 3'd4;
	localparam logic [2:0] ST_STEP   = 3'd5;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic             first_q;
	logic             out_valid_q;
	logic             slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.idx      = idx_q;
		cmd.use_quot = first_q;
		unique case (state_q)
			ST_IDLE:   cmd.load     = in_valid;
			ST_MUL_LO: cmd.mul_lo   = 1'b1;
			ST_MUL_HI: cmd.mul_hi   = 1'b1;
			ST_REM:    cmd.rem_calc = 1'b1;
			ST_FIX:    cmd.rem_fix  = 1'b1;
			ST_STEP:   cmd.emit     = slot_free;
			default:   cmd          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q   <= include_bills ? IDX_FIRST_BILL : IDX_FIRST_COIN;
						first_q <= 1'b1;
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_REM;
				ST_REM:    state_q <= ST_FIX;
				ST_FIX:    state_q <= ST_STEP;
				ST_STEP: begin
					if (slot_free) begin
						first_q <= 1'b0;
						if (idx_q == IDX_LAST) begin
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/gcm_dp.sv]
// Datapath for the greedy change maker: reciprocal-multiply division by the first
// denomination, compare-subtract for the rest, output registers. Depends on gcm_pkg.
module gcm_dp
	import gcm_pkg::*;
#(
	parameter int AMOUNT_BITS = 24
) (
	input  logic                   clk,
	input  gcm_cmd_t               cmd,
	input  logic [AMOUNT_BITS-1:0] amount_cents,
	output logic [DENOM_W-1:0]     denomination_cents,
	output logic [COUNT_W-1:0]     piece_count,
	output logic                   is_last
);

	// floor(2^AMOUNT_BITS / 200) needs AMOUNT_BITS-7 bits; the estimate
	// floor(x * recip / 2^AMOUNT_BITS) is the quotient or one below it
	localparam int R_W   = AMOUNT_BITS - 7;
	localparam int XL_W  = AMOUNT_BITS / 2;
	localparam int XH_W  = AMOUNT_BITS - XL_W;
	localparam int ACC_W = AMOUNT_BITS + R_W;
	localparam int RX_W  = DENOM_W + 1;
	localparam int QX_W  = (R_W > COUNT_W) ? R_W : COUNT_W;

	localparam logic [R_W-1:0] RECIP_BILL =
		R_W'((64'd1 << AMOUNT_BITS) / 64'(DENOM_TOP_BILL));
	localparam logic [R_W-1:0] RECIP_COIN =
		R_W'((64'd1 << AMOUNT_BITS) / 64'(DENOM_TOP_COIN));

	logic [AMOUNT_BITS-1:0] dvd_q;
	logic [ACC_W-1:0]       acc_q;
	logic [R_W-1:0]         quo_q;
	logic [RX_W-1:0]        diff_q;
	logic [DENOM_W-1:0]     rem_q;
	logic [DENOM_W-1:0]     denom_q;
	logic [COUNT_W-1:0]     count_q;
	logic                   last_q;

	logic [DENOM_W-1:0]     d;
	logic [R_W-1:0]         recip;
	logic [XL_W+R_W-1:0]    part_lo;
	logic [XH_W+R_W-1:0]    part_hi;
	logic [R_W-1:0]         quo_est;
	logic [RX_W-1:0]        prod;
	logic [RX_W-1:0]        diff;
	logic                   fix_up;
	logic [QX_W-1:0]        quo_x;
	logic [COUNT_W-1:0]     quo_sat;
	logic [DENOM_W:0]       rem_x;
	logic [DENOM_W:0]       d1_x;
	logic [DENOM_W:0]       d2_x;
	logic [COUNT_W-1:0]     step_cnt;
	logic [DENOM_W-1:0]     step_rem;

	assign d = denom_of(cmd.idx);

	// Quotient by the first denomination: two partial products, then the
	// remainder below 2d, worked modulo 2^17, then one correction
	always_comb begin
		recip   = (cmd.idx == IDX_FIRST_BILL) ? RECIP_BILL : RECIP_COIN;
		part_lo = (XL_W+R_W)'(dvd_q[XL_W-1:0]) * (XL_W+R_W)'(recip);
		part_hi = (XH_W+R_W)'(dvd_q[AMOUNT_BITS-1:XL_W]) * (XH_W+R_W)'(recip);
		quo_est = acc_q[ACC_W-1:AMOUNT_BITS];
		prod    = RX_W'(quo_est) * RX_W'(d);
		diff    = RX_W'(dvd_q) - prod;
		fix_up  = (diff_q >= RX_W'(d));
	end

	always_comb begin
		quo_x   = QX_W'(quo_q);
		quo_sat = (quo_x > QX_W'(COUNT_MAX)) ? COUNT_MAX : quo_x[COUNT_W-1:0];
	end

	// Later entries: remainder is below the previous denomination, so at most two pieces
	always_comb begin
		rem_x = {1'b0, rem_q};
		d1_x  = {1'b0, d};
		d2_x  = {d, 1'b0};
		if (rem_x >= d2_x) begin
			step_cnt = COUNT_W'(2);
			step_rem = DENOM_W'(rem_x - d2_x);
		end else if (rem_x >= d1_x) begin
			step_cnt = COUNT_W'(1);
			step_rem = DENOM_W'(rem_x - d1_x);
		end else begin
			step_cnt = '0;
			step_rem = rem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			dvd_q <= amount_cents;

		if (cmd.mul_lo)
			acc_q <= ACC_W'(part_lo);
		else if (cmd.mul_hi)
			acc_q <= acc_q + (ACC_W'(part_hi) << XL_W);

		if (cmd.rem_calc) begin
			quo_q  <= quo_est;
			diff_q <= diff;
		end else if (cmd.rem_fix && fix_up) begin
			quo_q <= quo_q + R_W'(1);
		end

		if (cmd.rem_fix)
			rem_q <= fix_up ? DENOM_W'(diff_q - RX_W'(d)) : diff_q[DENOM_W-1:0];
		else if (cmd.emit && !cmd.use_quot)
			rem_q <= step_rem;

		if (cmd.emit) begin
			denom_q <= d;
			count_q <= cmd.use_quot ? quo_sat : step_cnt;
			last_q  <= (cmd.idx == IDX_LAST);
		end
	end

	assign denomination_cents = denom_q;
	assign piece_count        = count_q;
	assign is_last            = last_q;

endmodule

[tb/sv/change_checker.sv]
// Result checker for the greedy change maker: predicts the payout of each amount
// and compares it with every result item, tracking include_bills from the APB port.
// Depends on gcm_pkg; change_tb_pkg below holds the register addresses for the bench.
package change_tb_pkg;

	import gcm_pkg::*;

	localparam logic [2:0] ADDR_INCLUDE_BILLS = 3'(4 * int'(REG_INCLUDE_BILLS));
	localparam logic [2:0] ADDR_SPARE         = 3'(4 * (int'(REG_INCLUDE_BILLS) + 1));

endpackage

module change_checker
	import gcm_pkg::*;
	import change_tb_pkg::*;
#(
	parameter int AMOUNT_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	input  logic [31:0]            prdata,
	input  logic                   pready,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [AMOUNT_BITS-1:0] amount_cents,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [DENOM_W-1:0]     denomination_cents,
	input  logic [COUNT_W-1:0]     piece_count,
	input  logic                   is_last,
	output int                     mismatches,
	output int                     pending,
	output int                     results_checked
);

	typedef struct packed {
		logic [DENOM_W-1:0] denom;
		logic [COUNT_W-1:0] count;
		logic               last;
	} payout_t;

	localparam int unsigned FACE_VALUES [NUM_DENOM] = '{
		50000, 20000, 10000, 5000, 2000, 1000, 500,
		200, 100, 50, 20, 10, 5, 2, 1
	};

	payout_t payouts_due[$];
	payout_t want;
	payout_t got;
	logic    notes_on;

	initial begin
		mismatches      = 0;
		pending         = 0;
		results_checked = 0;
	end

	// Walk the table from the first note or the first coin, keeping the remainder.
	function automatic void split_amount(input logic [AMOUNT_BITS-1:0] amount,
			input logic with_notes);
		longint unsigned rest;
		longint unsigned pieces;
		payout_t         p;
		int              i;
		rest = amount;
		for (i = with_notes ? 0 : NUM_BILLS; i < NUM_DENOM; i++) begin
			pieces  = rest / FACE_VALUES[i];
			rest    = rest % FACE_VALUES[i];
			p.denom = DENOM_W'(FACE_VALUES[i]);
			p.count = (pieces > COUNT_MAX) ? COUNT_MAX : COUNT_W'(pieces);
			p.last  = (i == NUM_DENOM - 1);
			payouts_due = {payouts_due, p};
		end
	endfunction

	function automatic void flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $time, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notes_on <= 1'b0;
			payouts_due.delete();
			pending  <= 0;
		end else begin
			if (psel && penable && pready && paddr == ADDR_INCLUDE_BILLS) begin
				if (pwrite)
					notes_on <= pwdata[0];
				else if (prdata !== 32'(notes_on))
					flag_mismatch($sformatf("include_bills read back %0h, expected %0h",
						prdata, notes_on));
			end
			if (in_valid && in_ready)
				split_amount(amount_cents, notes_on);
			if (out_valid && out_ready) begin
				results_checked++;
				got = '{denomination_cents, piece_count, is_last};
				if (payouts_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result denom=%0d count=%0d last=%0b",
						got.denom, got.count, got.last));
				end else begin
					want = payouts_due.pop_front();
					if (got !== want)
						flag_mismatch($sformatf({"expected denom=%0d count=%0d last=%0b, ",
							"got denom=%0d count=%0d last=%0b"}, want.denom, want.count,
							want.last, got.denom, got.count, got.last));
				end
			end
			pending <= payouts_due.size();
		end
	end

endmodule

[tb/sv/tb_greedy_change_maker.sv]
// Testbench top for the greedy change maker: clock, reset, APB set-up, amount
// stimulus and result back-pressure, plus the verdict.
// Depends on gcm_pkg, change_tb_pkg, change_checker and greedy_change_maker.
module tb_greedy_change_maker;

	import gcm_pkg::*;
	import change_tb_pkg::*;

	localparam int AMOUNT_BITS     = 24;
	localparam int CLK_PERIOD      = 12;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int RUN_LIMIT       = 400000;

	// Amounts that hit the edges of the table: zero, the smallest coins, a
	// sum that needs one of each coin, exact and just-short note values,
	// the largest amount and alternating bit patterns.
	localparam logic [AMOUNT_BITS-1:0] EDGE_AMOUNTS [12] = '{
		24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd388, 24'd199,
		24'd50000, 24'd49999, 24'hFFFFFF, 24'hAAAAAA, 24'h555555
	};

	typedef enum {FLOW, CHOPPY, CLOGGED} drain_style_e;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   psel         = 1'b0;
	logic                   penable      = 1'b0;
	logic                   pwrite       = 1'b0;
	logic [2:0]             paddr        = '0;
	logic [31:0]            pwdata       = '0;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	logic [AMOUNT_BITS-1:0] amount_cents = '0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic [DENOM_W-1:0]     denomination_cents;
	logic [COUNT_W-1:0]     piece_count;
	logic                   is_last;

	int   mismatches;
	int   pending;
	int   results_checked;

	logic hold_off_req   = 1'b0;
	int   burst_left     = 0;
	int   amounts_sent   = 0;
	int   directed_sent  = 0;
	int   writes_done    = 0;

	greedy_change_maker #(.AMOUNT_BITS(AMOUNT_BITS)) dut (.*);

	change_checker #(.AMOUNT_BITS(AMOUNT_BITS)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Offer one amount and hold it until the block takes it. Items come in
	// bursts; at the start of a burst drop valid for a random gap, or carry
	// straight on so that back-to-back items also occur.
	task automatic send_amount(input logic [AMOUNT_BITS-1:0] amount);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		amount_cents <= amount;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		amounts_sent++;
	endtask

	// Stop offering and wait until every predicted result has come back,
	// so that the block is idle before the register is touched.
	task automatic settle();
		in_valid  <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write one APB register, then read include_bills back in a second
	// transfer; the checker compares the read data with its own copy.
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_INCLUDE_BILLS;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		writes_done++;
	endtask

	task automatic run_directed();
		foreach (EDGE_AMOUNTS[i]) begin
			send_amount(EDGE_AMOUNTS[i]);
			directed_sent++;
		end
	endtask

	// Mix small change, amounts in the note range, near-multiples of the
	// 500 euro note, amounts just under the maximum and the full range.
	function automatic logic [AMOUNT_BITS-1:0] random_amount();
		case ($urandom_range(0, 4))
			0:       return AMOUNT_BITS'($urandom_range(0, 999));
			1:       return AMOUNT_BITS'($urandom_range(0, 199999));
			2:       return AMOUNT_BITS'($urandom_range(0, 335) * 50000 + $urandom_range(0, 2));
			3:       return '1 - AMOUNT_BITS'($urandom_range(0, 4999));
			default: return AMOUNT_BITS'($urandom());
		endcase
	endfunction

	task automatic run_random(input int count);
		repeat (count) send_amount(random_amount());
	endtask

	// Receiver: switch between free flow, choppy and clogged stretches of
	// random length. Once asked, hold ready low for a long stretch so that
	// the output register and then the input side back up.
	initial begin
		drain_style_e style;
		int           seg_left;
		bit           hold_done;
		style     = FLOW;
		seg_left  = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					style    = drain_style_e'($urandom_range(0, 2));
					seg_left = $urandom_range(20, 200);
				end
				seg_left--;
				case (style)
					FLOW:    out_ready <= 1'b1;
					CHOPPY:  out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Coins only, straight from reset.
		run_directed();
		settle();

		// Notes ahead of the coins.
		write_reg(ADDR_INCLUDE_BILLS, 32'h0000_0001);
		run_directed();
		settle();

		// Upper bits set, low bit clear: coins only again.
		write_reg(ADDR_INCLUDE_BILLS, 32'hFFFF_FFFE);
		run_random(150);
		settle();

		// A write to an unused address must leave the mode alone.
		write_reg(ADDR_SPARE, 32'h0000_0001);
		run_random(100);
		settle();

		// Notes on, with the long receiver hold-off while amounts keep coming.
		write_reg(ADDR_INCLUDE_BILLS, 32'h0000_0001);
		hold_off_req <= 1'b1;
		run_random(150);
		settle();

		write_reg(ADDR_INCLUDE_BILLS, 32'h0000_0000);
		run_random(50);
		settle();

		// Leave room for any stray result beyond the last expected one.
		repeat (2 * AMOUNT_BITS + 2 * NUM_DENOM) @(posedge clk);

		$display("Covered %0d amounts (%0d edge cases, %0d random) with and without notes,",
			amounts_sent, directed_sent, amounts_sent - directed_sent);
		$display("%0d results checked, %0d register writes each read back, %0d mismatches.",
			results_checked, writes_done, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#(CLK_PERIOD * RUN_LIMIT);
		$display("Timeout: results still outstanding or input never accepted");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
hdl/gcm_pkg.sv
hdl/gcm_ctrl.sv
hdl/gcm_dp.sv
hdl/greedy_change_maker.sv
tb/sv/change_checker.sv
tb/sv/tb_greedy_change_maker.sv
